// ===== rtl/mfc_pkg.sv =====
// Package: constants, types and membership functions of the fuzzy centroid unit
package mfc_pkg;
  localparam int OutPoints = 31;
  localparam int MfFrac = 8;
  localparam int MfW = MfFrac + 1;
  localparam int MfOne = 1 << MfFrac;
  localparam int KW = $clog2(OutPoints);
  localparam int AreaW = MfW + KW;
  localparam int MomW = AreaW + KW;
  localparam int CentW = 13;
  localparam int NumW = MomW + 14;
  localparam int DenW = AreaW + KW + 1;
  localparam int QW = 14;
  localparam int CentMax = 7680;

  typedef logic [MfW-1:0] mf_t;
  typedef logic [255:0][MfW-1:0] mf_tab_t;

  typedef struct packed {
    mf_t r1;
    mf_t r2;
    mf_t r3;
  } str_t;

  typedef struct packed {
    logic [AreaW-1:0] area;
    logic [MomW-1:0] moment;
  } acc_t;

  function automatic longint cdiv(input longint n, input longint d);
    longint q, r;
    q = 0;
    r = n;
    while (r >= d) begin
      r = r - d;
      q = q + 1;
    end
    return q;
  endfunction

  function automatic mf_t member(input int pos, input int scale, input int a, input int b,
                                 input int c, input int d);
    int pa, pb, pc, pd;
    longint t;
    pa = a * scale;
    pb = b * scale;
    pc = c * scale;
    pd = d * scale;
    if (pos <= pa) t = 0;
    else if (pos <= pb) t = cdiv(longint'(pos - pa) * MfOne, longint'(pb - pa));
    else if (pos <= pc) t = MfOne;
    else if (pos <= pd) t = cdiv(longint'(pd - pos) * MfOne, longint'(pd - pc));
    else t = 0;
    return mf_t'(t);
  endfunction

  function automatic mf_tab_t mf_table(input int a, input int b, input int c, input int d);
    mf_tab_t t;
    for (int i = 0; i < 256; i++) t[i] = member(i, 16, a, b, c, d);
    return t;
  endfunction

  function automatic mf_t max2(input mf_t p, input mf_t q);
    return (p > q) ? p : q;
  endfunction

  function automatic mf_t min2(input mf_t p, input mf_t q);
    return (p < q) ? p : q;
  endfunction

  localparam mf_tab_t SvcPoorTab = mf_table(-1, 0, 1, 4);
  localparam mf_tab_t FoodRancidTab = mf_table(-1, 0, 1, 3);
  localparam mf_tab_t SvcGoodTab = mf_table(1, 5, 5, 9);
  localparam mf_tab_t SvcExcelTab = mf_table(6, 9, 10, 10);
  localparam mf_tab_t FoodDelicTab = mf_table(7, 9, 10, 10);
endpackage

// ===== rtl/mfc_if.sv =====
// Interfaces: input and result channels
interface mfc_in_if (input logic clk);
  logic valid;
  logic ready;
  logic [7:0] service_level;
  logic [7:0] food_quality;
  modport source (output valid, service_level, food_quality, input ready);
  modport sink (input valid, service_level, food_quality, output ready);
endinterface

interface mfc_out_if (input logic clk);
  logic valid;
  logic ready;
  logic [12:0] tip_centroid;
  logic no_rule_fired;
  modport source (output valid, tip_centroid, no_rule_fired, input ready);
  modport sink (input valid, tip_centroid, no_rule_fired, output ready);
endinterface

// ===== rtl/mfc_cell.sv =====
// Cell: adds the clipped aggregate of one output sample to the running sums
module mfc_cell (
  input  logic                  clk,
  input  logic                  en,
  input  mfc_pkg::mf_t          m1_i,
  input  mfc_pkg::mf_t          m2_i,
  input  mfc_pkg::mf_t          m3_i,
  input  logic [mfc_pkg::KW-1:0] k_i,
  input  mfc_pkg::str_t         str_i,
  input  mfc_pkg::acc_t         acc_i,
  output mfc_pkg::str_t         str_o,
  output mfc_pkg::acc_t         acc_o
);
  import mfc_pkg::*;
  mf_t agg;
  str_t str_r;
  acc_t acc_r;
  assign agg = max2(min2(m1_i, str_i.r1), max2(min2(m2_i, str_i.r2), min2(m3_i, str_i.r3)));
  always_ff @(posedge clk) begin
    if (en) begin
      str_r <= str_i;
      acc_r.area <= acc_i.area + AreaW'(agg);
      acc_r.moment <= acc_i.moment + MomW'(agg) * MomW'(k_i);
    end
  end
  assign str_o = str_r;
  assign acc_o = acc_r;
endmodule

// ===== rtl/mfc_div_cell.sv =====
// Divider cell: one restoring quotient bit per stage
module mfc_div_cell (
  input  logic                    clk,
  input  logic                    en,
  input  logic [mfc_pkg::NumW:0]  rem_i,
  input  logic [mfc_pkg::NumW-1:0] num_i,
  input  logic [mfc_pkg::DenW-1:0] den_i,
  input  logic [mfc_pkg::QW-1:0]  q_i,
  input  logic                    z_i,
  output logic [mfc_pkg::NumW:0]  rem_o,
  output logic [mfc_pkg::NumW-1:0] num_o,
  output logic [mfc_pkg::DenW-1:0] den_o,
  output logic [mfc_pkg::QW-1:0]  q_o,
  output logic                    z_o
);
  import mfc_pkg::*;
  logic [NumW:0] sh, rem_r;
  logic [NumW-1:0] num_r;
  logic [DenW-1:0] den_r;
  logic [QW-1:0] q_r;
  logic z_r, ge;
  assign sh = {rem_i[NumW-1:0], num_i[NumW-1]};
  assign ge = sh >= (NumW+1)'(den_i);
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= ge ? sh - (NumW+1)'(den_i) : sh;
      num_r <= {num_i[NumW-2:0], 1'b0};
      den_r <= den_i;
      q_r <= {q_i[QW-2:0], ge};
      z_r <= z_i;
    end
  end
  assign rem_o = rem_r;
  assign num_o = num_r;
  assign den_o = den_r;
  assign q_o = q_r;
  assign z_o = z_r;
endmodule

// ===== rtl/mamdani_fuzzy_centroid_unit.sv =====
// Top level: fuzzification, sample cell chain, pipelined divider and output stage
// One word per cycle in and out while the output is not stalled. The pipe has one stage
// for rule strengths, one cell per output sample, one numerator scaling stage, and one
// divider cell per numerator bit. The whole pipe advances when the output stage can take
// a word, so a stalled result holds the chain without loss.
module mamdani_fuzzy_centroid_unit (
  input logic clk,
  input logic rst_n,
  mfc_in_if.sink in_ch,
  mfc_out_if.source out_ch
);
  import mfc_pkg::*;
  localparam int Depth = 1 + OutPoints + 1 + NumW;
  logic en;
  logic [Depth-1:0] vld_r;
  str_t str0_r;
  str_t strs [OutPoints+1];
  acc_t accs [OutPoints+1];
  logic [NumW:0] rems [NumW+1];
  logic [NumW-1:0] nums [NumW+1];
  logic [DenW-1:0] dens [NumW+1];
  logic [QW-1:0] qs [NumW+1];
  logic zs [NumW+1];
  logic [NumW-1:0] num_r;
  logic [DenW-1:0] den_r;
  logic z_r;
  logic ov_r, onr_r;
  logic [CentW-1:0] oc_r;

  assign en = !ov_r || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[Depth-2:0], in_ch.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      str0_r.r1 <= max2(SvcPoorTab[in_ch.service_level], FoodRancidTab[in_ch.food_quality]);
      str0_r.r2 <= SvcGoodTab[in_ch.service_level];
      str0_r.r3 <= max2(SvcExcelTab[in_ch.service_level], FoodDelicTab[in_ch.food_quality]);
    end
  end

  assign strs[0] = str0_r;
  assign accs[0] = '0;
  for (genvar k = 0; k < OutPoints; k++) begin : g_cell
    localparam mf_t M1 = member(30 * k, OutPoints - 1, 0, 5, 5, 10);
    localparam mf_t M2 = member(30 * k, OutPoints - 1, 10, 15, 15, 20);
    localparam mf_t M3 = member(30 * k, OutPoints - 1, 20, 25, 25, 30);
    mfc_cell u_cell (
      .clk, .en, .m1_i(M1), .m2_i(M2), .m3_i(M3), .k_i(KW'(k)),
      .str_i(strs[k]), .acc_i(accs[k]), .str_o(strs[k+1]), .acc_o(accs[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r <= NumW'(accs[OutPoints].moment) * NumW'(30 * 256 * 2)
               + NumW'(accs[OutPoints].area) * NumW'(OutPoints - 1);
      den_r <= DenW'(accs[OutPoints].area) * DenW'(2 * (OutPoints - 1));
      z_r <= accs[OutPoints].area == '0;
    end
  end

  assign rems[0] = '0;
  assign nums[0] = num_r;
  assign dens[0] = den_r;
  assign qs[0] = '0;
  assign zs[0] = z_r;
  for (genvar i = 0; i < NumW; i++) begin : g_div
    mfc_div_cell u_div (
      .clk, .en, .rem_i(rems[i]), .num_i(nums[i]), .den_i(dens[i]), .q_i(qs[i]),
      .z_i(zs[i]), .rem_o(rems[i+1]), .num_o(nums[i+1]), .den_o(dens[i+1]),
      .q_o(qs[i+1]), .z_o(zs[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en) begin
      ov_r <= vld_r[Depth-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      onr_r <= zs[NumW];
      if (zs[NumW]) oc_r <= '0;
      else if (qs[NumW] > QW'(CentMax)) oc_r <= CentW'(CentMax);
      else oc_r <= qs[NumW][CentW-1:0];
    end
  end

  assign out_ch.valid = ov_r;
  assign out_ch.tip_centroid = oc_r;
  assign out_ch.no_rule_fired = onr_r;

`ifndef NO_ASSERTIONS
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_ch.ready |=> ov_r && $stable(oc_r) && $stable(onr_r))
    else $error("result lost under stall");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && onr_r |-> oc_r == '0) else $error("nonzero centroid with no area");
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> oc_r <= CentW'(CentMax)) else $error("centroid out of range");
`endif
endmodule
